### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/ddct_pkg.sv
// Package with the types, constants and cosine weight function of the 8x8 DCT block.
`default_nettype none

package ddct_pkg;

    localparam int SIDE_BITS = 3;
    localparam int CELL_BITS = 6;
    localparam int SAMPLE_W  = 16;
    localparam int WEIGHT_W  = 16;
    localparam int PAIR_W    = 28;
    localparam int PROD_W    = 44;
    localparam int ACC_W     = 50;
    localparam int DROP_BITS = 28;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;

    // One multiply-accumulate request from the sequencer.
    typedef struct packed {
        logic    valid;
        logic    first;
        logic    last;
        weight_t w1;
        weight_t w2;
    } mac_issue_t;

    // Weight W[u][x] = alpha(u) * cos((2x+1) u pi / 16) in Q1.14.
    function automatic weight_t weight(input logic [SIDE_BITS-1:0] u,
                                       input logic [SIDE_BITS-1:0] x);
        logic [6:0] prod;
        logic [4:0] m;
        logic       neg;
        logic [13:0] mag;
        prod = {x, 1'b1} * u;
        m    = prod[4:0];
        neg  = 1'b0;
        if (m > 5'd16)
            m = 5'd0 - m;
        if (m > 5'd8)
        begin
            neg = 1'b1;
            m   = 5'd16 - m;
        end
        case (m)
            5'd0:    mag = 14'd8192;
            5'd1:    mag = 14'd8035;
            5'd2:    mag = 14'd7568;
            5'd3:    mag = 14'd6811;
            5'd4:    mag = 14'd5793;
            5'd5:    mag = 14'd4551;
            5'd6:    mag = 14'd3135;
            5'd7:    mag = 14'd1598;
            default: mag = 14'd0;
        endcase
        // The DC row uses alpha(0) = sqrt(1/8).
        if (u == '0)
            mag = 14'd5793;
        return neg ? -weight_t'({2'b00, mag}) : weight_t'({2'b00, mag});
    endfunction

endpackage

`default_nettype wire

### design/ddct_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
`default_nettype none

module ddct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/ddct_mac.sv
// Pipelined multiply-accumulate unit with final rounding and saturation.
`default_nettype none

module ddct_mac
    import ddct_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire mac_issue_t issue,
    input  wire sample_t    sample,
    output logic            done,
    output sample_t         result
);

    logic                     s1_v_reg, s1_first_reg, s1_last_reg;
    logic signed [PAIR_W-1:0] ww_reg;
    logic                     s2_v_reg, s2_first_reg, s2_last_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     fin_reg, done_reg;
    sample_t                  res_reg;

    logic signed [31:0]       ww_next;
    logic signed [ACC_W-1:0]  acc_next;
    logic        [ACC_W-1:0]  mag;
    logic        [ACC_W-1:0]  rnd;
    logic        [ACC_W-DROP_BITS-1:0] r;
    sample_t                  res_next;

    assign ww_next  = 32'(issue.w1) * 32'(issue.w2);
    assign acc_next = s2_first_reg ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);

    // Round to nearest, ties away from zero, then saturate.
    always_comb
    begin
        mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        rnd = mag + (ACC_W'(1) << (DROP_BITS - 1));
        r   = rnd[ACC_W-1:DROP_BITS];
        if (acc_reg[ACC_W-1])
            res_next = (r > (ACC_W-DROP_BITS)'(32768)) ? sample_t'(-32768)
                                                        : sample_t'(-r[SAMPLE_W-1:0]);
        else
            res_next = (r > (ACC_W-DROP_BITS)'(32767)) ? sample_t'(32767)
                                                        : sample_t'(r[SAMPLE_W-1:0]);
    end

    // Control flags of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= issue.valid;
            s2_v_reg <= s1_v_reg;
            fin_reg  <= s2_v_reg && s2_last_reg;
            done_reg <= fin_reg;
        end
    end

    // Weight pair product, sample product, accumulation and result.
    always_ff @(posedge clk)
    begin
        s1_first_reg <= issue.first;
        s1_last_reg  <= issue.last;
        ww_reg       <= ww_next[PAIR_W-1:0];
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        prod_reg     <= PROD_W'(sample) * PROD_W'(ww_reg);
        if (s2_v_reg)
            acc_reg <= acc_next;
        if (fin_reg)
            res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

### design/dct_idct_8x8_2d.sv
// Top level of the 8x8 forward/inverse orthonormal 2-D DCT block.
// Samples of a block are taken one per cycle while s_tvalid is high, in raster
// order, and stored in a sample memory. The block then takes no input while it
// produces the 64 results in raster order: each result is a 64-term sum computed
// by one shared multiply-accumulate pipeline that reads the sample memory one
// word per cycle; a result takes the issue of its 64 terms, the pipeline drain
// and the output state, plus the wait for its transfer. The mode register is
// taken when the last sample of a block arrives; m_tlast marks the 64th result.
`default_nettype none

module dct_idct_8x8_2d
    import ddct_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] sample_value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [15:0] result_value
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_data   // [0] mode
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_CALC  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [CELL_BITS-1:0] ld_cnt_reg, pq_reg, ab_reg;
    logic                 mode_reg, blk_mode_reg;
    sample_t              out_reg;
    logic [SAMPLE_W-1:0]  rdata;
    mac_issue_t           issue;
    logic                 mac_done;
    sample_t              mac_result;
    logic                 in_xfer, out_xfer;

    logic [SIDE_BITS-1:0] p, q, a, b;

    assign s_tready  = (state_reg == ST_LOAD);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_xfer  = m_tvalid && m_tready;
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = out_reg;
    assign m_tlast   = (pq_reg == '1);

    assign p = pq_reg[CELL_BITS-1:SIDE_BITS];
    assign q = pq_reg[SIDE_BITS-1:0];
    assign a = ab_reg[CELL_BITS-1:SIDE_BITS];
    assign b = ab_reg[SIDE_BITS-1:0];

    // Issue one term per cycle while computing.
    always_comb
    begin
        issue.valid = (state_reg == ST_CALC);
        issue.first = (ab_reg == '0);
        issue.last  = (ab_reg == '1);
        issue.w1    = blk_mode_reg ? weight(a, p) : weight(p, a);
        issue.w2    = blk_mode_reg ? weight(b, q) : weight(q, b);
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:  if (in_xfer && ld_cnt_reg == '1) state_next = ST_CALC;
            ST_CALC:  if (ab_reg == '1) state_next = ST_DRAIN;
            ST_DRAIN: if (mac_done) state_next = ST_OUT;
            ST_OUT:   if (out_xfer) state_next = (pq_reg == '1) ? ST_LOAD : ST_CALC;
            default:  state_next = ST_LOAD;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            ld_cnt_reg   <= '0;
            pq_reg       <= '0;
            ab_reg       <= '0;
            mode_reg     <= 1'b0;
            blk_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                mode_reg <= cfg_data[0];
            if (in_xfer)
                ld_cnt_reg <= ld_cnt_reg + CELL_BITS'(1);
            if (in_xfer && ld_cnt_reg == '1)
                blk_mode_reg <= mode_reg;
            if (state_reg == ST_CALC)
                ab_reg <= ab_reg + CELL_BITS'(1);
            if (out_xfer)
                pq_reg <= pq_reg + CELL_BITS'(1);
        end
    end

    // Output holding register.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DRAIN && mac_done)
            out_reg <= mac_result;
    end

    ddct_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(64)
    ) u_sample_ram (
        .clk  (clk),
        .we   (in_xfer),
        .waddr(ld_cnt_reg),
        .wdata(s_tdata),
        .raddr(ab_reg),
        .rdata(rdata)
    );

    ddct_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .issue (issue),
        .sample(sample_t'(rdata)),
        .done  (mac_done),
        .result(mac_result)
    );

endmodule

`default_nettype wire

### design/ddct_checker.sv
// Port-level checker for the DCT block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module ddct_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);

    // Input and output are never open together.
    `ASSERT_NEVER(a_no_overlap, clk, rst_n, s_tready && m_tvalid)
    // A stalled result holds.
    `ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // Input reopens only after the last result of a block is transferred.
    `ASSERT_IMPL(a_reopen, clk, rst_n, $rose(s_tready), $past(m_tvalid && m_tready && m_tlast))

endmodule

bind dct_idct_8x8_2d ddct_checker u_ddct_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

`default_nettype wire
